### rtl/core/mma_pkg.sv
package mma_pkg;

	localparam int CHAN_W       = 3;
	localparam int SAMPLE_W     = 10;
	localparam int AVG_W        = 10;
	localparam int DEF_WINDOW   = 16;
	localparam int DEF_CHANNELS = 6;

	typedef struct packed {
		logic [CHAN_W-1:0]   channel;
		logic [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_channel;
		logic [AVG_W-1:0]  average;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic upd;
		logic step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic in_range;
	} status_t;

endpackage

### rtl/core/multichannel_moving_average.sv
// Multichannel moving average over a window of WINDOW samples per channel.
// Input channel: in_valid / in_ready with in_data (channel, sample). Output
// channel: out_valid / out_ready with out_data (out_channel, average).
// Every accepted item yields exactly one result item, in order.
// A valid channel reads its oldest slot from the sample memory, updates the
// running sum, write position and fill count, then a restoring divider
// forms the average one quotient bit per cycle. The result passes through
// one memory read, one update, ten divider steps and the load of the
// output register, in that order. The block accepts the next item only
// once that result is loaded, so it holds one item at a time.
// An item for a channel at or above CHANNELS changes no state and returns
// an average of zero, skipping the divider. The divider sets the rate.
// The result sits in an output register; the block returns to accepting
// input as soon as it is loaded, even while the receiver stalls. A finished
// result that finds the output register still full waits there.
// Reset clears all sums, positions, fill counts and the output valid; the
// memory needs no clearing since the fill count masks unwritten slots.
module multichannel_moving_average #(
	parameter int WINDOW   = mma_pkg::DEF_WINDOW,
	parameter int CHANNELS = mma_pkg::DEF_CHANNELS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mma_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output mma_pkg::out_item_t out_data
);

	mma_pkg::cmd_t    cmd;
	mma_pkg::status_t status;

	mma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mma_datapath #(
		.WINDOW   (WINDOW),
		.CHANNELS (CHANNELS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule

### rtl/core/mma_ctrl.sv
module mma_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  mma_pkg::status_t status,
	output mma_pkg::cmd_t    cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	localparam int CW = $clog2(mma_pkg::AVG_W);

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RD;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				cnt_d   = '0;
				state_d = status.in_range ? S_DIV : S_DONE;
			end
			S_DIV: begin
				cmd.step = 1'b1;
				if (cnt_q == CW'(mma_pkg::AVG_W - 1)) begin
					state_d = S_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/mma_datapath.sv
module mma_datapath #(
	parameter int WINDOW   = mma_pkg::DEF_WINDOW,
	parameter int CHANNELS = mma_pkg::DEF_CHANNELS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mma_pkg::in_item_t  in_data,
	input  mma_pkg::cmd_t      cmd,
	output mma_pkg::status_t   status,
	output mma_pkg::out_item_t out_data
);

	localparam int SW_ = mma_pkg::SAMPLE_W;
	localparam int AV  = mma_pkg::AVG_W;
	localparam int PW  = $clog2(WINDOW);
	localparam int FW  = $clog2(WINDOW + 1);
	localparam int SUW = $clog2(((1 << SW_) - 1) * WINDOW + 1);
	localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNW = $clog2(CHANNELS + 1);
	localparam int CXW = (CNW > mma_pkg::CHAN_W) ? CNW : mma_pkg::CHAN_W;
	localparam int DEPTH = CHANNELS * WINDOW;
	localparam int AW  = $clog2(DEPTH);

	logic [SUW-1:0] sum_q  [CHANNELS];
	logic [PW-1:0]  pos_q  [CHANNELS];
	logic [FW-1:0]  fill_q [CHANNELS];
	logic [SW_-1:0] mem    [DEPTH];

	logic [mma_pkg::CHAN_W-1:0] ch_q;
	logic [SW_-1:0]             smp_q;
	logic [SW_-1:0]             rd_data_q;
	logic [FW-1:0]              rem_q;
	logic [FW-1:0]              div_q;
	logic [AV-1:0]              low_q;
	logic [AV-1:0]              quo_q;
	mma_pkg::out_item_t         out_q;

	logic [CXW-1:0] ch_ext;
	logic [CIW-1:0] cidx;
	logic           in_range;
	logic [AW-1:0]  addr;
	logic [SW_-1:0] old_val;
	logic [SUW-1:0] new_sum;
	logic [FW-1:0]  new_fill;
	logic [PW-1:0]  new_pos;
	logic [FW:0]    trial;

	assign ch_ext   = CXW'(ch_q);
	assign cidx     = ch_ext[CIW-1:0];
	assign in_range = (ch_ext < CXW'(CHANNELS));
	assign status.in_range = in_range;

	assign addr = AW'((AW+1)'(cidx) * (AW+1)'(WINDOW) + (AW+1)'(pos_q[cidx]));

	// Until a channel's ring is full, the slot being replaced was never written.
	assign old_val  = (fill_q[cidx] == FW'(WINDOW)) ? rd_data_q : '0;
	assign new_sum  = sum_q[cidx] - SUW'(old_val) + SUW'(smp_q);
	assign new_fill = (fill_q[cidx] == FW'(WINDOW)) ? fill_q[cidx] : fill_q[cidx] + 1'b1;
	assign new_pos  = (pos_q[cidx] == PW'(WINDOW - 1)) ? '0 : pos_q[cidx] + 1'b1;
	assign trial    = {rem_q, low_q[AV-1]};

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_data_q <= mem[addr];
		end
		if (cmd.upd && in_range) begin
			mem[addr] <= smp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sum_q[i]  <= '0;
				pos_q[i]  <= '0;
				fill_q[i] <= '0;
			end
		end else if (cmd.upd && in_range) begin
			sum_q[cidx]  <= new_sum;
			pos_q[cidx]  <= new_pos;
			fill_q[cidx] <= new_fill;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q  <= in_data.channel;
			smp_q <= in_data.sample;
		end
		if (cmd.upd) begin
			// The quotient fits in AV bits, so the upper sum bits are below the divisor.
			rem_q <= FW'(new_sum >> AV);
			low_q <= new_sum[AV-1:0];
			div_q <= new_fill;
			quo_q <= '0;
		end else if (cmd.step) begin
			if (trial >= {1'b0, div_q}) begin
				rem_q <= FW'(trial - {1'b0, div_q});
				quo_q <= {quo_q[AV-2:0], 1'b1};
			end else begin
				rem_q <= trial[FW-1:0];
				quo_q <= {quo_q[AV-2:0], 1'b0};
			end
			low_q <= {low_q[AV-2:0], 1'b0};
		end
		if (cmd.out_load) begin
			out_q.out_channel <= ch_q;
			out_q.average     <= quo_q;
		end
	end

	assign out_data = out_q;

endmodule

### rtl/core/mma_checker.sv
module mma_checker #(
	parameter int CHANNELS = mma_pkg::DEF_CHANNELS
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input mma_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item dropped or changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while one is in progress");

	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $rose(in_ready))
		else $error("new result without the block returning to accept input");

	a_bad_channel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.out_channel >= CHANNELS) |-> out_data.average == '0)
		else $error("nonzero average for a channel out of range");

endmodule

bind multichannel_moving_average mma_checker #(
	.CHANNELS (CHANNELS)
) u_mma_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

### verif/mma_checker.sv
`timescale 1ns / 1ps

module mma_scoreboard #(
	parameter int WINDOW   = mma_pkg::DEF_WINDOW,
	parameter int CHANNELS = mma_pkg::DEF_CHANNELS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  mma_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  mma_pkg::out_item_t out_data,
	output int                 mismatches,
	output int                 outstanding
);

	localparam int SUM_W  = mma_pkg::SAMPLE_W + $clog2(WINDOW);
	localparam int POS_W  = $clog2(WINDOW);
	localparam int FILL_W = $clog2(WINDOW + 1);

	logic [mma_pkg::SAMPLE_W-1:0] ring [CHANNELS][WINDOW];
	logic [SUM_W-1:0]             win_sum [CHANNELS];
	logic [POS_W-1:0]             wr_pos [CHANNELS];
	logic [FILL_W-1:0]            fill [CHANNELS];

	mma_pkg::out_item_t avg_expected [$];
	mma_pkg::out_item_t want;

	// Folds one sample into its channel's window and returns the new average.
	function automatic mma_pkg::out_item_t average_after(input mma_pkg::in_item_t it);
		mma_pkg::out_item_t res;
		int ch;
		logic [POS_W-1:0] p;
		ch = int'(it.channel);
		res.out_channel = it.channel;
		res.average = '0;
		if (ch < CHANNELS) begin
			p = wr_pos[ch];
			win_sum[ch] = win_sum[ch] - ring[ch][p] + it.sample;
			ring[ch][p] = it.sample;
			wr_pos[ch] = (p == WINDOW - 1) ? '0 : p + 1'b1;
			if (fill[ch] < WINDOW) begin
				fill[ch] = fill[ch] + 1'b1;
			end
			res.average = mma_pkg::AVG_W'(win_sum[ch] / fill[ch]);
		end
		return res;
	endfunction

	task automatic report(input string what, input int got, input int exp_val);
		mismatches++;
		$display("%0t: %s: got %0d, expected %0d", $realtime, what, got, exp_val);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				for (int s = 0; s < WINDOW; s++) begin
					ring[c][s] = '0;
				end
				win_sum[c] = '0;
				wr_pos[c] = '0;
				fill[c] = '0;
			end
			avg_expected.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready) begin
				avg_expected.push_back(average_after(in_data));
			end
			if (out_valid && out_ready) begin
				if (avg_expected.size() == 0) begin
					report("result item with nothing pending", int'(out_data.average), -1);
				end else begin
					want = avg_expected.pop_front();
					if (out_data.out_channel !== want.out_channel) begin
						report("out_channel", int'(out_data.out_channel),
							int'(want.out_channel));
					end
					if (out_data.average !== want.average) begin
						report("average", int'(out_data.average), int'(want.average));
					end
				end
			end
			outstanding <= avg_expected.size();
		end
	end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	mma_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_ready;
	mma_pkg::out_item_t out_data;

	int send_idle;
	int recv_idle;
	int mismatches;
	int outstanding;

	multichannel_moving_average dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	mma_scoreboard chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send(input mma_pkg::in_item_t it);
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Bursts on one channel run the window through fill-up and wrap-around.
	task automatic random_phase(input int n);
		int left;
		int ch;
		int burst;
		int mode;
		int level;
		mma_pkg::in_item_t it;
		left = n;
		while (left > 0) begin
			if ($urandom_range(9) == 0) begin
				ch = $urandom_range(7, mma_pkg::DEF_CHANNELS);
			end else begin
				ch = $urandom_range(mma_pkg::DEF_CHANNELS - 1);
			end
			burst = $urandom_range(1, 24);
			if (burst > left) begin
				burst = left;
			end
			mode = $urandom_range(3);
			level = $urandom_range(1023);
			repeat (burst) begin
				it.channel = mma_pkg::CHAN_W'(ch);
				case (mode)
					0: it.sample = mma_pkg::SAMPLE_W'($urandom_range(1023));
					1: it.sample = $urandom_range(1) ? '1 : '0;
					2: it.sample = mma_pkg::SAMPLE_W'(level);
					default: begin
						it.channel = mma_pkg::CHAN_W'($urandom_range(7));
						it.sample = mma_pkg::SAMPLE_W'($urandom());
					end
				endcase
				send(it);
				left--;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		send_idle = 16;
		recv_idle = 71;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(mma_pkg::in_item_t'{3'd7, 10'h3FF});
		send(mma_pkg::in_item_t'{3'd6, 10'h000});
		send(mma_pkg::in_item_t'{3'd0, 10'h000});
		send(mma_pkg::in_item_t'{3'd0, 10'h3FF});
		send(mma_pkg::in_item_t'{3'd5, 10'h3FF});
		send(mma_pkg::in_item_t'{3'd5, 10'h001});
		repeat (17) send(mma_pkg::in_item_t'{3'd3, 10'h3FF});
		send(mma_pkg::in_item_t'{3'd3, 10'h000});
		drain();

		random_phase(375);
		drain();

		send_idle = 71;
		recv_idle = 16;
		random_phase(375);
		drain();

		send_idle = 0;
		recv_idle = 0;
		random_phase(375);
		drain();

		repeat (30) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
